[hw/rtl/hkv_pkg.sv]
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared constants, types and request codes of the hashed key/value table.
// ----------------------------------------------------------------------------
package hkv_pkg;

  localparam int BUCKETS  = 64;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 29;
  localparam int VALUE_W  = 64;

  localparam int IN_BITS  = REQ_W + KEY_W + VALUE_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + VALUE_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [WAYS-1:0]     way_mask_t;
  typedef key_t   [WAYS-1:0]   key_row_t;
  typedef value_t [WAYS-1:0]   value_row_t;

  typedef struct packed {
    logic       found;
    logic       bucket_full;
    value_t     value_out;
    way_mask_t  valid_next;
    key_row_t   key_next;
    value_row_t value_next;
  } upd_t;

endpackage

[hw/rtl/hashed_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// hashed_key_value_table_top
// Bucketed key/value store with per-bucket way compare and row write-back.
// ----------------------------------------------------------------------------
// Path: an input transaction is registered into stage s1, and its result into
//   the output register, which holds it while m_axis_tready is low.
// Throughput: one transaction per cycle when the output is not stalled, set by
//   the single row read and write-back of the bucket memory, with forwarding of back-to-back rows.
// Reset: synchronous; clears all way valid flip-flops together, so no clearing
//   pass is needed and input is taken as soon as reset is released.
module hashed_key_value_table_top import hkv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type[1:0], key[30:2], value_in[94:31], zero pad[95]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // found[0], value_out[64:1], bucket_full[65], zero pad[71:66]
  output logic [OUT_W-1:0] m_axis_tdata
);

  req_t       in_req;
  key_t       in_key;
  value_t     in_value;
  bucket_t    in_bucket;
  logic       accept;
  logic       advance;

  logic       s1_valid;
  req_t       s1_req;
  key_t       s1_key;
  value_t     s1_value;
  bucket_t    s1_bucket;

  key_row_t   rd_keys;
  value_row_t rd_values;
  logic       fwd;
  key_row_t   fwd_keys;
  value_row_t fwd_values;

  key_row_t   key_mem   [BUCKETS];
  value_row_t value_mem [BUCKETS];
  way_mask_t  valid     [BUCKETS];

  key_row_t   cur_keys;
  value_row_t cur_values;
  upd_t       upd;

  logic       out_valid;
  logic       out_found;
  value_t     out_value;
  logic       out_full;

  assign in_req    = s_axis_tdata[REQ_W-1:0];
  assign in_key    = s_axis_tdata[REQ_W+KEY_W-1:REQ_W];
  assign in_value  = s_axis_tdata[REQ_W+KEY_W+VALUE_W-1:REQ_W+KEY_W];
  assign in_bucket = BUCKET_W'(in_key % BUCKETS);

  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cur_keys   = fwd ? fwd_keys   : rd_keys;
  assign cur_values = fwd ? fwd_values : rd_values;

  hkv_way_match u_match (
    .req_type  (s1_req),
    .key       (s1_key),
    .value_in  (s1_value),
    .valid_row (valid[s1_bucket]),
    .key_row   (cur_keys),
    .value_row (cur_values),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      fwd      <= advance && (s1_bucket == in_bucket);
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req     <= in_req;
      s1_key     <= in_key;
      s1_value   <= in_value;
      s1_bucket  <= in_bucket;
      fwd_keys   <= upd.key_next;
      fwd_values <= upd.value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_mem[s1_bucket]   <= upd.key_next;
      value_mem[s1_bucket] <= upd.value_next;
    end
    if (accept) begin
      rd_keys   <= key_mem[in_bucket];
      rd_values <= value_mem[in_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid[b] <= '0;
      end
    end else if (advance) begin
      valid[s1_bucket] <= upd.valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found <= upd.found;
      out_value <= upd.value_out;
      out_full  <= upd.bucket_full;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_full, out_value, out_found};

endmodule

[hw/rtl/hkv_way_match.sv]
// ----------------------------------------------------------------------------
// hkv_way_match
// Compare a key against every way of one bucket and form the result and the
// updated bucket contents.
// ----------------------------------------------------------------------------
module hkv_way_match import hkv_pkg::*; (
  input  req_t       req_type,
  input  key_t       key,
  input  value_t     value_in,
  input  way_mask_t  valid_row,
  input  key_row_t   key_row,
  input  value_row_t value_row,
  output upd_t       upd
);

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             free_found;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_row[w]) begin
        if (!hit_found && key_row[w] == key) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    upd.found       = 1'b0;
    upd.bucket_full = 1'b0;
    upd.value_out   = '0;
    upd.valid_next  = valid_row;
    upd.key_next    = key_row;
    upd.value_next  = value_row;
    unique case (req_type)
      REQ_INSERT: begin
        if (hit_found) begin
          upd.found               = 1'b1;
          upd.value_next[hit_way] = value_in;
        end else if (free_found) begin
          upd.valid_next[free_way] = 1'b1;
          upd.key_next[free_way]   = key;
          upd.value_next[free_way] = value_in;
        end else begin
          upd.bucket_full = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (hit_found) begin
          upd.found     = 1'b1;
          upd.value_out = value_row[hit_way];
        end
      end
      REQ_DELETE: begin
        if (hit_found) begin
          upd.found               = 1'b1;
          upd.valid_next[hit_way] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/hkv_checker.sv]
// ----------------------------------------------------------------------------
// hkv_checker
// Port-level checks on the result stream of the hashed key/value table.
// ----------------------------------------------------------------------------
module hkv_checker import hkv_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_found_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[VALUE_W+1]))
    else $error("found and bucket_full both set");

  a_value_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[VALUE_W:1] != '0) |-> m_axis_tdata[0])
    else $error("value returned without a hit");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:OUT_BITS] == '0))
    else $error("result padding not zero");

endmodule

bind hashed_key_value_table_top hkv_checker u_hkv_checker (.*);

[dv/hashed_key_value_table_top_tb.sv]
// ----------------------------------------------------------------------------
// hashed_key_value_table_top_tb
// Self-checking bench for the bucketed key/value store. A table of directed
// requests covers empty-table misses, the widest keys and values, unused
// request codes, updates, a full bucket and deletes. Random requests follow,
// drawn mostly from small pools of colliding keys so that hits, refills and
// full buckets are common. Replies are checked field by field against a directed
// row's reply or a behavioural copy of the table; both streams idle at random.
// ----------------------------------------------------------------------------
module hashed_key_value_table_top_tb;
  import hkv_pkg::*;

  localparam req_t REQ_UNUSED  = 2'd3;
  localparam key_t KEY_MAX     = {KEY_W{1'b1}};
  localparam key_t KEY_TOP_B0  = {{(KEY_W - BUCKET_W){1'b1}}, {BUCKET_W{1'b0}}};
  localparam value_t ONES      = {VALUE_W{1'b1}};
  localparam int ENTRIES       = BUCKETS * WAYS;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 175;
  localparam int POOL_SIZE     = 30;
  localparam int POOL_BUCKETS  = 6;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 5000;

  typedef struct packed {
    logic   found;
    value_t value_out;
    logic   bucket_full;
  } reply_t;

  typedef struct packed {
    req_t   req;
    key_t   key;
    value_t value;
    bit     typed;
    reply_t reply;
  } stim_row_t;

  localparam reply_t R_MISS     = '{1'b0, 64'd0, 1'b0};
  localparam reply_t R_HIT      = '{1'b1, 64'd0, 1'b0};
  localparam reply_t R_HIT_ONES = '{1'b1, ONES, 1'b0};
  localparam reply_t R_FULL     = '{1'b0, 64'd0, 1'b1};

  stim_row_t dir_rows [0:21] = '{
    '{REQ_LOOKUP, 29'd0,      64'd0,                 1'b1, R_MISS},
    '{REQ_DELETE, 29'd5,      64'd0,                 1'b1, R_MISS},
    '{REQ_UNUSED, KEY_MAX,    ONES,                  1'b1, R_MISS},
    '{REQ_INSERT, 29'd0,      ONES,                  1'b1, R_MISS},
    '{REQ_LOOKUP, 29'd0,      64'd0,                 1'b1, R_HIT_ONES},
    '{REQ_INSERT, 29'd0,      64'd0,                 1'b1, R_HIT},
    '{REQ_LOOKUP, 29'd0,      ONES,                  1'b1, R_HIT},
    '{REQ_INSERT, 29'd64,     64'h5555_5555_5555_5555, 1'b0, R_MISS},
    '{REQ_INSERT, 29'd128,    64'h0F0F_0F0F_0F0F_0F0F, 1'b0, R_MISS},
    '{REQ_INSERT, KEY_TOP_B0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, R_MISS},
    '{REQ_INSERT, 29'd192,    64'h0000_0000_0000_1234, 1'b1, R_FULL},
    '{REQ_LOOKUP, KEY_TOP_B0, 64'd0,                 1'b0, R_MISS},
    '{REQ_UNUSED, 29'd0,      64'd0,                 1'b1, R_MISS},
    '{REQ_DELETE, 29'd64,     ONES,                  1'b1, R_HIT},
    '{REQ_INSERT, 29'd192,    64'hFEDC_BA98_7654_3210, 1'b0, R_MISS},
    '{REQ_LOOKUP, 29'd64,     64'd0,                 1'b1, R_MISS},
    '{REQ_INSERT, KEY_MAX,    64'h0123_4567_89AB_CDEF, 1'b0, R_MISS},
    '{REQ_LOOKUP, KEY_MAX,    64'd0,                 1'b0, R_MISS},
    '{REQ_DELETE, KEY_MAX,    64'd0,                 1'b1, R_HIT},
    '{REQ_DELETE, KEY_MAX,    64'd0,                 1'b1, R_MISS},
    '{REQ_LOOKUP, 29'd192,    64'd0,                 1'b0, R_MISS},
    '{REQ_LOOKUP, 29'd128,    64'd0,                 1'b0, R_MISS}
  };

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // req_type[1:0], key[30:2], value_in[94:31], zero pad[95]
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // found[0], value_out[64:1], bucket_full[65], zero pad[71:66]
  logic [OUT_W-1:0] m_axis_tdata;

  bit     slot_used  [ENTRIES];
  key_t   slot_key   [ENTRIES];
  value_t slot_value [ENTRIES];

  reply_t pending_replies [$];

  int errors;
  int replies_checked;
  int sent_count [4];
  int lookup_hits;
  int full_refusals;

  hashed_key_value_table_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reply_t table_apply(req_t req, key_t key, value_t value);
    int     base;
    int     hit;
    int     vacant;
    reply_t rep;
    base   = (key % BUCKETS) * WAYS;
    hit    = -1;
    vacant = -1;
    rep    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_used[base + w]) begin
        if (hit < 0 && slot_key[base + w] == key) hit = w;
      end else if (vacant < 0) begin
        vacant = w;
      end
    end
    case (req)
      REQ_INSERT: begin
        if (hit >= 0) begin
          rep.found = 1'b1;
          slot_value[base + hit] = value;
        end else if (vacant >= 0) begin
          slot_used[base + vacant]  = 1'b1;
          slot_key[base + vacant]   = key;
          slot_value[base + vacant] = value;
        end else begin
          rep.bucket_full = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          rep.found     = 1'b1;
          rep.value_out = slot_value[base + hit];
        end
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          rep.found = 1'b1;
          slot_used[base + hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic offer(input req_t req, input key_t key, input value_t value,
                       input bit typed, input reply_t typed_reply, input bit idle_on);
    reply_t rep;
    int     gap;
    int     pick;
    s_axis_tdata  <= {1'b0, value, key, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    rep = table_apply(req, key, value);
    pending_replies.push_back(typed ? typed_reply : rep);
    sent_count[req]++;
    if (req == REQ_LOOKUP && rep.found) lookup_hits++;
    if (rep.bucket_full) full_refusals++;
    gap = 0;
    if (idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(5, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    key_t    key_pool [POOL_SIZE];
    bucket_t base;
    req_t    req;
    key_t    key;
    value_t  value;
    int      pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].req, dir_rows[i].key, dir_rows[i].value,
            dir_rows[i].typed, dir_rows[i].reply, 1'b1);
    end
    for (int phase = 0; phase < PHASES; phase++) begin
      base = bucket_t'($urandom);
      foreach (key_pool[i]) begin
        key_pool[i] = key_t'($urandom);
        key_pool[i][BUCKET_W-1:0] = base + bucket_t'(i % POOL_BUCKETS);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) req = REQ_INSERT;
        else if (pick < 70) req = REQ_LOOKUP;
        else if (pick < 92) req = REQ_DELETE;
        else req = REQ_UNUSED;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = key_t'($urandom);
        pick = $urandom_range(0, 15);
        if (pick == 0) value = '0;
        else if (pick == 1) value = ONES;
        else value = {$urandom, $urandom};
        offer(req, key, value, 1'b0, R_MISS, phase != 1);
      end
      // hold off until the table has answered everything sent so far
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (pending_replies.size() != 0);
    end
    repeat (8) @(posedge clk);
    $display("Sent %0d inserts, %0d lookups, %0d deletes, %0d unused codes; %0d replies checked",
             sent_count[REQ_INSERT], sent_count[REQ_LOOKUP], sent_count[REQ_DELETE],
             sent_count[REQ_UNUSED], replies_checked);
    $display("Lookup hits %0d, full-bucket refusals %0d, mismatches %0d",
             lookup_hits, full_refusals, errors);
    if (errors == 0) begin
      $display("hashed_key_value_table_top_tb OK");
    end else begin
      $display("hashed_key_value_table_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    reply_t want;
    int     cycle;
    int     hold_left;
    int     stall_left;
    bit     held;
    bit     rdy;
    m_axis_tready = 1'b0;
    cycle      = 0;
    hold_left  = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          replies_checked++;
          if (m_axis_tdata[0] !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[VALUE_W:1] !== want.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                     m_axis_tdata[VALUE_W:1]);
            errors++;
          end
          if (m_axis_tdata[VALUE_W+1] !== want.bucket_full) begin
            $display("%0t: bucket_full expected %0b actual %0b", $time, want.bucket_full,
                     m_axis_tdata[VALUE_W+1]);
            errors++;
          end
        end
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && replies_checked >= 150) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
        rdy       = 1'b0;
      end else if ((cycle / 256) % 3 != 0) begin
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
          stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
          rdy = 1'b0;
        end
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("hashed_key_value_table_top_tb NOT OK");
    $finish;
  end

endmodule
